### design/kmhr_pkg.sv
// kmhr_pkg: shared types and constants for the key matrix report block
// depends on nothing; used by the controller, the datapath and the top level

package kmhr_pkg;

  // item opcodes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_EOS    = 2'd2;

  // configuration register indexes
  localparam logic CFG_TRANSPARENT = 1'b0;
  localparam logic CFG_FN          = 1'b1;

  localparam logic [7:0] CFG_TRANSPARENT_RST = 8'd1;
  localparam logic [7:0] CFG_FN_RST          = 8'd192;

  localparam logic [7:0] HID_REPORT_TAG = 8'd2;
  localparam logic [7:0] MOD_FIRST      = 8'd224;
  localparam logic [7:0] MOD_LAST       = 8'd231;
  localparam logic [7:0] MOD_BIT_MASK   = 8'h07;

  // keymap layers, fixed by the layer select field
  localparam int LAYERS = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MAP,
    ST_CODE,
    ST_EOS_WR,
    ST_RING_RD,
    ST_RING_ACC,
    ST_EMIT
  } kmhr_state_t;

  typedef struct packed {
    logic item_ld;
    logic km_wr;
    logic latch_clr;
    logic latch_rd;
    logic map;
    logic fallback;
    logic apply;
    logic eos_wr;
    logic ring_rd;
    logic ring_acc;
    logic emit_ld;
  } kmhr_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       in_range;
    logic       pressed;
    logic       need_fb;
    logic       ring_last;
    logic       emit_last;
    logic       out_free;
  } kmhr_status_t;

endpackage

### design/key_matrix_hid_reporter.sv
// key_matrix_hid_reporter: keyboard matrix scanner with two layers and an nkro report
// load item or released key: exec only; pressed key: exec, map and code, code again
// on layer zero fallback; end of scan: ring write and fold, then BITMAP_BYTES+2 bytes,
// one per cycle while out_stall is low; in_stall is high from acceptance until done
// synchronous active-low reset clears latches, layer, report, ring valid bits and pointer
// keymap contents stay undefined until loaded; no clearing pass is run

module key_matrix_hid_reporter #(
  parameter int ROWS          = 9,
  parameter int COLS          = 9,
  parameter int BITMAP_BYTES  = 16,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic       in_layer_sel,
  input  logic [3:0] in_row,
  input  logic [3:0] in_col,
  input  logic [7:0] in_code,
  input  logic       in_pressed,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_byte_index,
  output logic [7:0] out_report_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  kmhr_pkg::kmhr_cmd_t    cmd;
  kmhr_pkg::kmhr_status_t sts;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  kmhr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kmhr_datapath #(
    .ROWS          (ROWS),
    .COLS          (COLS),
    .BITMAP_BYTES  (BITMAP_BYTES),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_layer_sel    (in_layer_sel),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_code         (in_code),
    .in_pressed      (in_pressed),
    .cfg_valid       (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte_index  (out_byte_index),
    .out_report_byte (out_report_byte),
    .out_last        (out_last)
  );

endmodule

### design/kmhr_ctrl.sv
// kmhr_ctrl: sequencer for load, sample and end-of-scan requests
// depends on kmhr_pkg; drives commands into kmhr_datapath

module kmhr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kmhr_pkg::kmhr_status_t sts,
  output kmhr_pkg::kmhr_cmd_t   cmd
);

  kmhr_pkg::kmhr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kmhr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      kmhr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.item_ld = 1'b1;
          state_nxt   = kmhr_pkg::ST_EXEC;
        end
      end
      kmhr_pkg::ST_EXEC: begin
        state_nxt = kmhr_pkg::ST_IDLE;
        case (sts.op)
          kmhr_pkg::OP_LOAD: begin
            cmd.km_wr = sts.in_range;
          end
          kmhr_pkg::OP_SAMPLE: begin
            if (sts.in_range) begin
              if (!sts.pressed) begin
                cmd.latch_clr = 1'b1;
              end else begin
                cmd.latch_rd = 1'b1;
                state_nxt    = kmhr_pkg::ST_MAP;
              end
            end
          end
          kmhr_pkg::OP_EOS: begin
            state_nxt = kmhr_pkg::ST_EOS_WR;
          end
          default: begin
            state_nxt = kmhr_pkg::ST_IDLE;
          end
        endcase
      end
      kmhr_pkg::ST_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = kmhr_pkg::ST_CODE;
      end
      kmhr_pkg::ST_CODE: begin
        // transparent code on layer one re-reads layer zero
        if (sts.need_fb) begin
          cmd.fallback = 1'b1;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = kmhr_pkg::ST_IDLE;
        end
      end
      kmhr_pkg::ST_EOS_WR: begin
        cmd.eos_wr = 1'b1;
        state_nxt  = kmhr_pkg::ST_RING_RD;
      end
      kmhr_pkg::ST_RING_RD: begin
        cmd.ring_rd = 1'b1;
        state_nxt   = kmhr_pkg::ST_RING_ACC;
      end
      kmhr_pkg::ST_RING_ACC: begin
        cmd.ring_acc = 1'b1;
        state_nxt    = sts.ring_last ? kmhr_pkg::ST_EMIT : kmhr_pkg::ST_RING_RD;
      end
      kmhr_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          if (sts.emit_last) begin
            state_nxt = kmhr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = kmhr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/kmhr_datapath.sv
// kmhr_datapath: keymap, key latches, scan report, history ring and output register
// depends on kmhr_pkg; steered by kmhr_ctrl

module kmhr_datapath #(
  parameter int ROWS          = 9,
  parameter int COLS          = 9,
  parameter int BITMAP_BYTES  = 16,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kmhr_pkg::kmhr_cmd_t    cmd,
  output kmhr_pkg::kmhr_status_t sts,
  input  logic [1:0]             in_op,
  input  logic                   in_layer_sel,
  input  logic [3:0]             in_row,
  input  logic [3:0]             in_col,
  input  logic [7:0]             in_code,
  input  logic                   in_pressed,
  input  logic                   cfg_valid,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [4:0]             out_byte_index,
  output logic [7:0]             out_report_byte,
  output logic                   out_last
);

  localparam int CELLS      = ROWS * COLS;
  localparam int CELL_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int KM_DEPTH   = kmhr_pkg::LAYERS * CELLS;
  localparam int KM_W       = $clog2(KM_DEPTH);
  localparam int SCAN_BYTES = BITMAP_BYTES + 1;
  localparam int SCAN_BITS  = SCAN_BYTES * 8;
  localparam int BM_BITS    = BITMAP_BYTES * 8;
  localparam int BIT_W      = $clog2(BM_BITS);
  localparam int H_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W      = $clog2(SCAN_BYTES + 1);

  // configuration
  logic [7:0] trans_r;
  logic [7:0] fn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r <= kmhr_pkg::CFG_TRANSPARENT_RST;
      fn_r    <= kmhr_pkg::CFG_FN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        kmhr_pkg::CFG_TRANSPARENT: trans_r <= cfg_data;
        kmhr_pkg::CFG_FN:          fn_r    <= cfg_data;
        default:                   trans_r <= trans_r;
      endcase
    end
  end

  // request capture
  logic [1:0]        op_r;
  logic              layer_sel_r;
  logic [7:0]        code_r;
  logic              pressed_r;
  logic              in_range_r;
  logic [CELL_W-1:0] cell_r;
  logic [8:0]        cell_full;
  logic              in_range_c;

  assign cell_full  = 9'(in_row) * 9'(COLS) + 9'(in_col);
  assign in_range_c = (5'(in_row) < 5'(ROWS)) && (5'(in_col) < 5'(COLS));

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      op_r        <= in_op;
      layer_sel_r <= in_layer_sel;
      code_r      <= in_code;
      pressed_r   <= in_pressed;
      in_range_r  <= in_range_c;
      cell_r      <= cell_full[CELL_W-1:0];
    end
  end

  // key latches: valid bit per cell, latched layer in a small memory
  logic [CELLS-1:0] lvalid_r;
  logic             lay_mem [CELLS];
  logic             lay_rd_r;
  logic             lv_cap_r;
  logic             layer_r;
  logic             active_layer_r;
  logic             lay_c;

  assign lay_c = lv_cap_r ? lay_rd_r : active_layer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r <= '0;
    end else if (cmd.latch_clr) begin
      lvalid_r[cell_r] <= 1'b0;
    end else if (cmd.map) begin
      lvalid_r[cell_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_rd) begin
      lay_rd_r <= lay_mem[cell_r];
      lv_cap_r <= lvalid_r[cell_r];
    end
    if (cmd.map && !lv_cap_r) begin
      lay_mem[cell_r] <= active_layer_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      layer_r <= lay_c;
    end else if (cmd.fallback) begin
      layer_r <= 1'b0;
    end
  end

  // keymap memory
  logic [7:0]      km_mem [KM_DEPTH];
  logic [7:0]      km_rd_r;
  logic [9:0]      km_wa_full;
  logic [9:0]      km_ra_full;
  logic            km_rd_layer;

  assign km_rd_layer = cmd.map ? lay_c : 1'b0;
  assign km_wa_full  = 10'(cell_r) + (layer_sel_r ? 10'(CELLS) : 10'd0);
  assign km_ra_full  = 10'(cell_r) + (km_rd_layer ? 10'(CELLS) : 10'd0);

  always_ff @(posedge clk) begin
    if (cmd.km_wr) begin
      km_mem[km_wa_full[KM_W-1:0]] <= code_r;
    end
    if (cmd.map || cmd.fallback) begin
      km_rd_r <= km_mem[km_ra_full[KM_W-1:0]];
    end
  end

  // scan report
  logic [7:0]         mod_r, mod_nxt;
  logic [BM_BITS-1:0] bm_r, bm_nxt;
  logic               fn_seen_r, fn_seen_nxt;
  logic               is_mod;
  logic               in_bm;
  logic [2:0]         mod_sel;

  assign is_mod  = (km_rd_r >= kmhr_pkg::MOD_FIRST) && (km_rd_r <= kmhr_pkg::MOD_LAST);
  assign in_bm   = 9'(km_rd_r) < 9'(BM_BITS);
  assign mod_sel = 3'(km_rd_r & kmhr_pkg::MOD_BIT_MASK);

  always_comb begin
    mod_nxt     = mod_r;
    bm_nxt      = bm_r;
    fn_seen_nxt = fn_seen_r;
    if (cmd.apply && (km_rd_r != trans_r)) begin
      if (is_mod) begin
        mod_nxt[mod_sel] = 1'b1;
      end else if (km_rd_r == fn_r) begin
        fn_seen_nxt = 1'b1;
      end else if (in_bm) begin
        bm_nxt[km_rd_r[BIT_W-1:0]] = 1'b1;
      end
    end
    if (cmd.eos_wr) begin
      mod_nxt     = '0;
      bm_nxt      = '0;
      fn_seen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r          <= '0;
      bm_r           <= '0;
      fn_seen_r      <= 1'b0;
      active_layer_r <= 1'b0;
    end else begin
      mod_r     <= mod_nxt;
      bm_r      <= bm_nxt;
      fn_seen_r <= fn_seen_nxt;
      if (cmd.eos_wr) begin
        active_layer_r <= fn_seen_r;
      end
    end
  end

  // history ring, one scan's modifier and bitmap bytes per row
  logic [SCAN_BITS-1:0]     ring_mem [HISTORY_DEPTH];
  logic [SCAN_BITS-1:0]     ring_rd_r;
  logic [HISTORY_DEPTH-1:0] rvalid_r;
  logic [H_W-1:0]           ptr_r;
  logic [H_W-1:0]           ptr_nxt;
  logic [H_W-1:0]           ridx_r;
  logic [SCAN_BITS-1:0]     acc_r;
  logic [CNT_W-1:0]         cnt_r;

  assign ptr_nxt = (ptr_r == H_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + H_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvalid_r <= '0;
      ptr_r    <= '0;
    end else if (cmd.eos_wr) begin
      rvalid_r[ptr_nxt] <= 1'b1;
      ptr_r             <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eos_wr) begin
      ring_mem[ptr_nxt] <= {bm_r, mod_r};
    end
    if (cmd.ring_rd) begin
      ring_rd_r <= ring_mem[ridx_r];
    end
  end

  // rows never written read as zero
  always_ff @(posedge clk) begin
    if (cmd.eos_wr) begin
      acc_r  <= '0;
      ridx_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.ring_acc) begin
      if (rvalid_r[ridx_r]) begin
        acc_r <= acc_r | ring_rd_r;
      end
      ridx_r <= ridx_r + H_W'(1);
    end else if (cmd.emit_ld) begin
      if (cnt_r != '0) begin
        acc_r <= acc_r >> 8;
      end
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // output register
  logic       out_valid_r;
  logic [4:0] out_idx_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [31:0] cnt_ext;

  assign cnt_ext = 32'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_idx_r  <= cnt_ext[4:0];
      out_byte_r <= (cnt_r == '0) ? kmhr_pkg::HID_REPORT_TAG : acc_r[7:0];
      out_last_r <= cnt_r == CNT_W'(SCAN_BYTES);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte_index  = out_idx_r;
  assign out_report_byte = out_byte_r;
  assign out_last        = out_last_r;

  assign sts.op        = op_r;
  assign sts.in_range  = in_range_r;
  assign sts.pressed   = pressed_r;
  assign sts.need_fb   = (km_rd_r == trans_r) && layer_r;
  assign sts.ring_last = ridx_r == H_W'(HISTORY_DEPTH - 1);
  assign sts.emit_last = cnt_r == CNT_W'(SCAN_BYTES);
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule
